[design/brc_pkg.sv]
`timescale 1ns / 1ps
package brc_pkg;

    localparam int ROW_BITS_W = 20;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [1:0] REG_PIXEL_BITS_LOG2 = 2'd0;
    localparam logic [1:0] REG_SRC_PIXEL_OFFSET = 2'd1;
    localparam logic [1:0] REG_DST_PIXEL_OFFSET = 2'd2;
    localparam logic [1:0] REG_ROW_WIDTH_PIXELS = 2'd3;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       first_of_row;
    } src_in_t;

    typedef struct packed {
        logic [7:0] dst_byte;
        logic [7:0] write_mask;
        logic       last_of_row;
    } dst_out_t;

    // leading ones: 0 -> 0x00, 1 -> 0x80 ... 8 -> 0xff
    function automatic logic [7:0] lead_mask(input logic [3:0] cnt);
        return ~(8'hff >> cnt);
    endfunction

endpackage

[design/bit_aligned_row_copy_core.sv]
`timescale 1ns / 1ps
// packed pixel bit realigner
// s_ channel: one source row byte per transaction; first_of_row marks the byte holding
// the row's first pixel and restarts the row (any unfinished row is dropped).
// m_ channel: destination bytes with a bit write mask for merging partial first and last
// bytes; last_of_row flags the row's final byte. One source byte gives zero, one or two
// destination bytes.
// APB port: pixel_bits_log2 at 0x0, src_pixel_offset at 0x4, dst_pixel_offset at 0x8,
// row_width_pixels at 0xc; sampled when a row starts.
// A result is written to the result queue as its source byte is accepted and is offered on m_ from there.
// Throughput: one source byte per cycle while s_ready is high, set by the carry and shift update
// feeding a four-entry result queue; s_ready is high while the queue has at least two free entries.
// Reset clears the queue and the row state; registers return to 8-bit pixels, zero
// offsets and a width of one pixel.
// When the receiver stalls, results wait in the queue and source bytes keep flowing
// until it has fewer than two free entries.
module bit_aligned_row_copy_core #(
    parameter int MAX_ROW_PIXELS = 65536
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  brc_pkg::src_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output brc_pkg::dst_out_t               m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [brc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [brc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [brc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import brc_pkg::*;

    function automatic logic [2:0] bit_offset(input logic [1:0] lg, input logic [2:0] pix);
        logic [2:0] m;
        m = 3'b111 >> lg;
        return 3'((pix & m) << lg);
    endfunction

    logic [1:0]  pixel_bits_log2_reg;
    logic [2:0]  src_pixel_offset_reg;
    logic [2:0]  dst_pixel_offset_reg;
    logic [16:0] row_width_pixels_reg;

    logic [7:0]            carry_bits_reg, carry_bits_next;
    logic [2:0]            carry_count_reg, carry_count_next;
    logic [ROW_BITS_W-1:0] row_bits_left_reg, row_bits_left_next;
    logic                  first_pending_reg, first_pending_next;
    logic [2:0]            skip_bits_reg, skip_bits_next;
    logic [2:0]            dst_skip_reg, dst_skip_next;

    dst_out_t                q_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]  count_reg, count_next;
    logic [QUEUE_PTR_W-1:0]  wr_ptr_plus1;

    logic                  cfg_write;
    logic                  accept;
    logic                  pop;
    logic [16:0]           width_sat;
    logic [7:0]            carry_eff;
    logic [2:0]            cc_eff;
    logic [ROW_BITS_W-1:0] rbl_eff;
    logic                  fop_eff;
    logic [2:0]            skip_eff;
    logic [2:0]            dskip_eff;
    logic                  active;
    logic [3:0]            take_full;
    logic [3:0]            take;
    logic [7:0]            bits;
    logic [ROW_BITS_W-1:0] rbl_new;
    logic [15:0]           acc0, acc1, acc2;
    logic [3:0]            total0, total1, total2;
    logic [3:0]            cnt1, cnt2;
    logic [7:0]            mask1, mask2;
    logic                  emit1, emit2;
    dst_out_t              res0, res1;

    // configuration port
    assign cfg_write = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_bits_log2_reg  <= 2'd3;
            src_pixel_offset_reg <= 3'd0;
            dst_pixel_offset_reg <= 3'd0;
            row_width_pixels_reg <= 17'd1;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_PIXEL_BITS_LOG2:  pixel_bits_log2_reg  <= pwdata[1:0];
                REG_SRC_PIXEL_OFFSET: src_pixel_offset_reg <= pwdata[2:0];
                REG_DST_PIXEL_OFFSET: dst_pixel_offset_reg <= pwdata[2:0];
                REG_ROW_WIDTH_PIXELS: row_width_pixels_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PIXEL_BITS_LOG2:  prdata = {30'd0, pixel_bits_log2_reg};
            REG_SRC_PIXEL_OFFSET: prdata = {29'd0, src_pixel_offset_reg};
            REG_DST_PIXEL_OFFSET: prdata = {29'd0, dst_pixel_offset_reg};
            REG_ROW_WIDTH_PIXELS: prdata = {15'd0, row_width_pixels_reg};
            default:              prdata = '0;
        endcase
    end

    // handshakes
    assign s_ready = (count_reg < QUEUE_CNT_W'(QUEUE_DEPTH - 1));
    assign accept = s_valid & s_ready;
    assign m_valid = (count_reg != '0);
    assign pop = m_valid & m_ready;
    assign m_data = q_reg[rd_ptr_reg];

    // row start
    always_comb begin
        if ({15'd0, row_width_pixels_reg} > 32'(MAX_ROW_PIXELS)) begin
            width_sat = 17'(MAX_ROW_PIXELS);
        end else begin
            width_sat = row_width_pixels_reg;
        end
        if (s_data.first_of_row) begin
            dskip_eff = bit_offset(pixel_bits_log2_reg, dst_pixel_offset_reg);
            carry_eff = 8'd0;
            cc_eff    = bit_offset(pixel_bits_log2_reg, dst_pixel_offset_reg);
            rbl_eff   = ROW_BITS_W'({3'd0, width_sat} << pixel_bits_log2_reg);
            fop_eff   = 1'b1;
            skip_eff  = bit_offset(pixel_bits_log2_reg, src_pixel_offset_reg);
        end else begin
            dskip_eff = dst_skip_reg;
            carry_eff = carry_bits_reg;
            cc_eff    = carry_count_reg;
            rbl_eff   = row_bits_left_reg;
            fop_eff   = first_pending_reg;
            skip_eff  = skip_bits_reg;
        end
    end

    // bit gather and byte emission
    always_comb begin
        active    = (rbl_eff != '0);
        take_full = 4'd8 - {1'b0, skip_eff};
        if (rbl_eff < ROW_BITS_W'(take_full)) begin
            take = rbl_eff[3:0];
        end else begin
            take = take_full;
        end
        bits    = 8'(s_data.src_byte << skip_eff) & lead_mask(take);
        rbl_new = rbl_eff - ROW_BITS_W'(take);
        acc0    = {carry_eff, 8'd0} | 16'({8'd0, bits} << (4'd8 - {1'b0, cc_eff}));
        total0  = {1'b0, cc_eff} + take;

        emit1  = active && (total0 != '0) && (total0 >= 4'd8 || rbl_new == '0);
        cnt1   = (total0 >= 4'd8) ? 4'd8 : total0;
        total1 = total0 - cnt1;
        mask1  = lead_mask(cnt1) & (fop_eff ? (8'hff >> dskip_eff) : 8'hff);
        res0.dst_byte    = acc0[15:8] & mask1;
        res0.write_mask  = mask1;
        res0.last_of_row = (rbl_new == '0) && (total1 == '0);
        acc1   = {acc0[7:0], 8'd0};

        emit2  = emit1 && (total1 != '0) && (total1 >= 4'd8 || rbl_new == '0);
        cnt2   = (total1 >= 4'd8) ? 4'd8 : total1;
        total2 = total1 - cnt2;
        mask2  = lead_mask(cnt2);
        res1.dst_byte    = acc1[15:8] & mask2;
        res1.write_mask  = mask2;
        res1.last_of_row = (rbl_new == '0) && (total2 == '0);
        acc2   = {acc1[7:0], 8'd0};
    end

    // state update
    always_comb begin
        carry_bits_next    = carry_bits_reg;
        carry_count_next   = carry_count_reg;
        row_bits_left_next = row_bits_left_reg;
        first_pending_next = first_pending_reg;
        skip_bits_next     = skip_bits_reg;
        dst_skip_next      = dst_skip_reg;
        if (accept) begin
            carry_bits_next    = carry_eff;
            carry_count_next   = cc_eff;
            row_bits_left_next = rbl_eff;
            first_pending_next = fop_eff;
            skip_bits_next     = skip_eff;
            dst_skip_next      = dskip_eff;
            if (active) begin
                row_bits_left_next = rbl_new;
                skip_bits_next     = 3'd0;
                if (emit2) begin
                    carry_bits_next  = acc2[15:8];
                    carry_count_next = total2[2:0];
                end else if (emit1) begin
                    carry_bits_next  = acc1[15:8];
                    carry_count_next = total1[2:0];
                end else begin
                    carry_bits_next  = acc0[15:8];
                    carry_count_next = total0[2:0];
                end
                if (emit1) begin
                    first_pending_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_bits_reg    <= '0;
            carry_count_reg   <= '0;
            row_bits_left_reg <= '0;
            first_pending_reg <= 1'b1;
            skip_bits_reg     <= '0;
            dst_skip_reg      <= '0;
        end else begin
            carry_bits_reg    <= carry_bits_next;
            carry_count_reg   <= carry_count_next;
            row_bits_left_reg <= row_bits_left_next;
            first_pending_reg <= first_pending_next;
            skip_bits_reg     <= skip_bits_next;
            dst_skip_reg      <= dst_skip_next;
        end
    end

    // result queue
    assign wr_ptr_plus1 = wr_ptr_reg + QUEUE_PTR_W'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept && emit2) begin
            wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(2);
            count_next  = count_next + QUEUE_CNT_W'(2);
        end else if (accept && emit1) begin
            wr_ptr_next = wr_ptr_plus1;
            count_next  = count_next + QUEUE_CNT_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(1);
            count_next  = count_next - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && emit1) begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (accept && emit2) begin
            q_reg[wr_ptr_plus1] <= res1;
        end
    end

endmodule

[design/brc_checker.sv]
`timescale 1ns / 1ps
module brc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input brc_pkg::src_in_t                s_data,
    input logic                            m_valid,
    input logic                            m_ready,
    input brc_pkg::dst_out_t               m_data,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [brc_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [brc_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [brc_pkg::APB_DATA_W-1:0]  prdata,
    input logic                            pready
);
    import brc_pkg::*;

    // queue empties on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled transaction holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // bits outside the mask are zero
    a_byte_in_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.dst_byte & ~m_data.write_mask) == 8'h00)
        else $error("data bit outside write mask");

    // only the last byte of a row may stop short of the low bit
    a_full_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_of_row |-> m_data.write_mask[0])
        else $error("partial tail before end of row");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel |-> pready)
        else $error("pready low");

endmodule

bind bit_aligned_row_copy_core brc_checker u_brc_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

class row_copy_scoreboard #(int unsigned ROW_LIMIT = 65536);
    logic [1:0]  pix_lg;
    logic [2:0]  src_off;
    logic [2:0]  dst_off;
    logic [16:0] width_px;

    logic [7:0]  carry;
    logic [3:0]  carry_n;
    logic [19:0] bits_left;
    logic        first_pend;
    logic [2:0]  skip_n;
    logic [2:0]  dst_skip;

    brc_pkg::dst_out_t expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
        pix_lg = 2'd3;
        src_off = '0;
        dst_off = '0;
        width_px = 17'd1;
        carry = '0;
        carry_n = '0;
        bits_left = '0;
        first_pend = 1'b1;
        skip_n = '0;
        dst_skip = '0;
        mismatches = 0;
        results_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            brc_pkg::REG_PIXEL_BITS_LOG2: pix_lg = val[1:0];
            brc_pkg::REG_SRC_PIXEL_OFFSET: src_off = val[2:0];
            brc_pkg::REG_DST_PIXEL_OFFSET: dst_off = val[2:0];
            brc_pkg::REG_ROW_WIDTH_PIXELS: width_px = val[16:0];
            default: ;
        endcase
    endfunction

    // pixel index within a byte scaled to a bit index
    function logic [2:0] bit_off(logic [2:0] pix);
        int unsigned ppb;
        ppb = 8 >> pix_lg;
        return 3'(((pix & (ppb - 1)) << pix_lg) & 7);
    endfunction

    function logic [7:0] lead_ones(int unsigned n);
        return 8'(16'hff00 >> n);
    endfunction

    function void note_input(brc_pkg::src_in_t d);
        int unsigned w;
        int unsigned take;
        int unsigned total;
        int unsigned cnt;
        int unsigned acc;
        logic [7:0] bits;
        logic [7:0] mask;
        brc_pkg::dst_out_t r;
        if (d.first_of_row) begin
            w = width_px;
            if (w > ROW_LIMIT) w = ROW_LIMIT;
            dst_skip = bit_off(dst_off);
            carry = '0;
            carry_n = {1'b0, dst_skip};
            bits_left = 20'(w << pix_lg);
            first_pend = 1'b1;
            skip_n = bit_off(src_off);
        end
        if (bits_left == 0) return;
        take = 8 - skip_n;
        if (take > bits_left) take = bits_left;
        bits = (d.src_byte << skip_n) & lead_ones(take);
        skip_n = '0;
        bits_left = bits_left - 20'(take);
        acc = ((32'(carry) << 8) | (32'(bits) << (8 - carry_n))) & 32'hffff;
        total = carry_n + take;
        while (total > 0 && (total >= 8 || bits_left == 0)) begin
            cnt = (total >= 8) ? 8 : total;
            mask = lead_ones(cnt);
            if (first_pend) mask = mask & (8'hff >> dst_skip);
            total = total - cnt;
            r.dst_byte = 8'(acc >> 8) & mask;
            r.write_mask = mask;
            r.last_of_row = (bits_left == 0) && (total == 0);
            expected_q.push_back(r);
            acc = (acc << 8) & 32'hffff;
            first_pend = 1'b0;
        end
        carry = 8'(acc >> 8);
        carry_n = 4'(total);
    endfunction

    function void check_result(brc_pkg::dst_out_t got);
        brc_pkg::dst_out_t exp_r;
        results_seen++;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: byte %02h mask %02h last %0b",
                         got.dst_byte, got.write_mask, got.last_of_row);
            return;
        end
        exp_r = expected_q.pop_front();
        if (got.dst_byte !== exp_r.dst_byte || got.write_mask !== exp_r.write_mask ||
            got.last_of_row !== exp_r.last_of_row) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected byte %02h mask %02h last %0b,",
                         exp_r.dst_byte, exp_r.write_mask, exp_r.last_of_row,
                         " got byte %02h mask %02h last %0b",
                         got.dst_byte, got.write_mask, got.last_of_row);
        end
    endfunction
endclass

module tb;
    import brc_pkg::*;

    localparam int unsigned MAX_PIX = 65536;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    src_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    dst_out_t              m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    row_copy_scoreboard #(MAX_PIX) sb;

    int unsigned src_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned n_rows;
    int unsigned n_row_bytes;
    int unsigned n_noise;
    int unsigned n_writes;

    bit_aligned_row_copy_core #(
        .MAX_ROW_PIXELS(MAX_PIX)
    ) u_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (s_valid && s_ready) sb.note_input(s_data);
        end
    end

    task automatic send_item(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{src_byte: b, first_of_row: first};
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
        n_writes++;
    endtask

    task automatic set_config(input int unsigned lg, input int unsigned src,
                              input int unsigned dst, input int unsigned width);
        wait_idle();
        reg_write(REG_PIXEL_BITS_LOG2, lg);
        reg_write(REG_SRC_PIXEL_OFFSET, src);
        reg_write(REG_DST_PIXEL_OFFSET, dst);
        reg_write(REG_ROW_WIDTH_PIXELS, width);
    endtask

    // broken rows stop early; the next row start drops them
    task automatic send_row(input bit broken);
        int unsigned w;
        int unsigned nbytes;
        int unsigned nsend;
        w = (sb.width_px > MAX_PIX) ? MAX_PIX : sb.width_px;
        nbytes = (sb.bit_off(sb.src_off) + (w << sb.pix_lg) + 7) / 8;
        if (nbytes == 0) nbytes = 1;
        nsend = (broken && nbytes > 1) ? $urandom_range(1, nbytes - 1) : nbytes;
        for (int unsigned i = 0; i < nsend; i++) begin
            send_item(8'($urandom), i == 0);
            n_row_bytes++;
        end
        n_rows++;
    endtask

    task automatic run_random(input int unsigned goal);
        int unsigned stop_at;
        int unsigned sel;
        int unsigned w;
        int unsigned nrows;
        bit broken;
        stop_at = n_row_bytes + goal;
        while (n_row_bytes < stop_at) begin
            sel = $urandom_range(99);
            if (sel < 5) w = 0;
            else if (sel < 12) w = $urandom_range(41, 160);
            else w = $urandom_range(1, 40);
            set_config($urandom_range(0, 3), $urandom_range(0, 7), $urandom_range(0, 7), w);
            nrows = $urandom_range(1, 4);
            for (int unsigned r = 0; r < nrows; r++) begin
                broken = (r != nrows - 1) && ($urandom_range(99) < 15);
                send_row(broken);
                if (!broken && $urandom_range(4) == 0) begin
                    repeat ($urandom_range(1, 2)) begin
                        send_item(8'($urandom), 1'b0);
                        n_noise++;
                    end
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_rows = 0;
        n_row_bytes = 0;
        n_noise = 0;
        n_writes = 0;
        sb = new();
        src_idle_pct = 13;
        rcv_idle_pct = 76;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: one 8-bit pixel, then a byte outside any row
        send_item(8'hff, 1'b1);
        send_item(8'h00, 1'b0);
        n_row_bytes++;
        n_noise++;
        set_config(0, 7, 3, 1);
        send_row(1'b0);
        set_config(1, 5, 6, 0);
        send_row(1'b0);
        set_config(2, 1, 1, 5);
        send_row(1'b1);
        send_row(1'b0);
        set_config(3, 7, 7, 3);
        send_row(1'b0);
        set_config(0, 3, 5, 13);
        send_row(1'b0);
        send_row(1'b0);

        run_random(270);
        src_idle_pct = 76;
        rcv_idle_pct = 13;
        run_random(270);
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        // width above the row limit, cut short by the next row start
        set_config(0, 2, 6, 17'h1ffff);
        for (int unsigned i = 0; i < 16; i++) begin
            send_item(8'($urandom), i == 0);
            n_row_bytes++;
        end
        n_rows++;
        run_random(260);

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("covered %0d rows from %0d source transactions plus %0d outside rows",
                 n_rows, n_row_bytes, n_noise);
        $display("checked %0d results over %0d register writes, %0d mismatches, %0d outstanding",
                 sb.results_seen, n_writes, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

[sim.f]
design/brc_pkg.sv
design/bit_aligned_row_copy_core.sv
design/brc_checker.sv
sim/tb.sv
